[hdl/pfvm_pkg.sv]
// Package for the PCM/FM volume mixer: transaction structs, register
// indexes, gain tables and the gain decode function. No dependencies.
package pfvm_pkg;

    typedef struct packed {
        logic               func;
        logic signed [15:0] pcm_left;
        logic signed [15:0] pcm_right;
        logic signed [15:0] fm_left;
        logic signed [15:0] fm_right;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
    } t_out_item;

    // per-stage load enables, handed from the pipeline control to each lane
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CARD_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_REG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_REG    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_EN     = 2'd3;

    localparam logic [2:0] CARD_PRO_FIRST = 3'd4;
    localparam logic [2:0] CARD_16BIT     = 3'd6;

    localparam logic [2:0] RST_CARD_TYPE = 3'd5;
    localparam logic [7:0] RST_VOICE_REG = 8'd255;
    localparam logic [7:0] RST_FM_REG    = 8'd255;
    localparam logic       RST_FM_EN     = 1'b1;

    // k*256/3, k*256/7, k*256/15, truncated
    localparam logic [8:0] GAIN_3 [4] = '{9'd0, 9'd85, 9'd170, 9'd256};
    localparam logic [8:0] GAIN_7 [8] = '{9'd0, 9'd36, 9'd73, 9'd109,
                                          9'd146, 9'd182, 9'd219, 9'd256};
    localparam logic [8:0] GAIN_15 [16] = '{9'd0, 9'd17, 9'd34, 9'd51,
                                            9'd68, 9'd85, 9'd102, 9'd119,
                                            9'd136, 9'd153, 9'd170, 9'd187,
                                            9'd204, 9'd221, 9'd238, 9'd256};

    function automatic logic [8:0] decode_gain(input logic [2:0] card,
                                               input logic [7:0] mreg,
                                               input logic       is_voice);
        logic [8:0] g;
        if (card < CARD_PRO_FIRST) begin
            if (is_voice) begin
                g = GAIN_3[mreg[2:1]];
            end else begin
                g = GAIN_7[mreg[3:1]];
            end
        end else if (card == CARD_16BIT) begin
            g = GAIN_15[mreg[7:4]];
        end else begin
            g = GAIN_7[mreg[7:5]];
        end
        return g;
    endfunction

endpackage

[hdl/pfvm_lane.sv]
// One audio channel of the mixer: gain scaling, offset, product mix and
// clamp over four register stages. Depends on pfvm_pkg.
module pfvm_lane (
    input  logic                i_clk,
    input  pfvm_pkg::t_stage_en i_en,
    input  logic                i_dig,
    input  logic                i_fm,
    input  logic signed [15:0]  i_pcm,
    input  logic signed [15:0]  i_fmo,
    input  logic [8:0]          i_vg,
    input  logic [8:0]          i_fg,
    output logic signed [15:0]  o_mix
);
    import pfvm_pkg::*;

    // stage 1: gain products
    logic signed [25:0] r1_pp, r1_fp;
    logic               r1_dig, r1_fm;
    // stage 2: scaled samples
    logic signed [15:0] r2_v, r2_f;
    logic               r2_dig, r2_fm;
    // stage 3: offset samples and their product
    logic [15:0]        r3_a, r3_b;
    logic [31:0]        r3_prod;
    logic signed [15:0] r3_v, r3_f;
    logic               r3_dig, r3_fm;
    // stage 4: output register
    logic signed [15:0] r_mix;

    logic signed [25:0] n_pp, n_fp, pp_adj, fp_adj;
    logic [15:0]        n_a, n_b;
    logic [16:0]        quo;
    logic [17:0]        sum2, hi_mix;
    logic [16:0]        m;
    logic [15:0]        mix_u;
    logic signed [15:0] n_mix;

    assign n_pp = i_pcm * $signed({1'b0, i_vg});
    assign n_fp = i_fmo * $signed({1'b0, i_fg});

    // truncation toward zero on the divide by 256
    assign pp_adj = r1_pp + (r1_pp[25] ? 26'sd255 : 26'sd0);
    assign fp_adj = r1_fp + (r1_fp[25] ? 26'sd255 : 26'sd0);

    assign n_a = {~r2_v[15], r2_v[14:0]};
    assign n_b = {~r2_f[15], r2_f[14:0]};

    always_comb begin
        quo    = r3_prod[31:15];
        sum2   = {1'b0, r3_a, 1'b0} + {1'b0, r3_b, 1'b0};
        hi_mix = sum2 - {1'b0, quo} - 18'd65536;
        if (!r3_a[15] || !r3_b[15]) begin
            m = quo;
        end else begin
            m = hi_mix[16:0];
        end
        mix_u = m[16] ? 16'hFFFF : m[15:0];
        if (r3_dig && r3_fm) begin
            n_mix = $signed({~mix_u[15], mix_u[14:0]});
        end else if (r3_dig) begin
            n_mix = r3_v;
        end else if (r3_fm) begin
            n_mix = r3_f;
        end else begin
            n_mix = 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_pp  <= n_pp;
            r1_fp  <= n_fp;
            r1_dig <= i_dig;
            r1_fm  <= i_fm;
        end
        if (i_en.s2) begin
            r2_v   <= pp_adj[23:8];
            r2_f   <= fp_adj[23:8];
            r2_dig <= r1_dig;
            r2_fm  <= r1_fm;
        end
        if (i_en.s3) begin
            r3_a    <= n_a;
            r3_b    <= n_b;
            r3_prod <= n_a * n_b;
            r3_v    <= r2_v;
            r3_f    <= r2_f;
            r3_dig  <= r2_dig;
            r3_fm   <= r2_fm;
        end
        if (i_en.s4) begin
            r_mix <= n_mix;
        end
    end

    assign o_mix = r_mix;

endmodule

[hdl/pcm_fm_volume_mixer.sv]
// Top level of the PCM/FM volume mixer: config registers, gain decode,
// pipeline valid/stall control and two channel lanes. Uses pfvm_pkg, pfvm_lane.
//
//  port group    dir  handshake            payload
//  in frame      in   i_valid / o_stall    i_item (t_in_item)
//  out frame     out  o_valid / i_stall    o_item (t_out_item)
//  config        in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// One frame per cycle unless i_stall holds it; valid passes r_v1, r_v2, r_v3, r_vo.
// Four register stages per lane: gain multiply, divide by 256, 16x16 product, mix.
// Synchronous active-low reset clears stage valids and loads register defaults.
// Stall is per stage: bubbles are squeezed out, so input is held off only when
// every stage is full and the output transaction is stalled.
module pcm_fm_volume_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  pfvm_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output pfvm_pkg::t_out_item                 o_item,
    input  logic                                i_cfg_we,
    input  logic [pfvm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pfvm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pfvm_pkg::*;

    logic [2:0] r_card_type;
    logic [7:0] r_voice_reg;
    logic [7:0] r_fm_reg;
    logic       r_fm_en;

    logic r_v1, r_v2, r_v3, r_vo;
    t_stage_en st_en;
    logic [8:0] vg, fg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_type <= RST_CARD_TYPE;
            r_voice_reg <= RST_VOICE_REG;
            r_fm_reg    <= RST_FM_REG;
            r_fm_en     <= RST_FM_EN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CARD_TYPE: r_card_type <= i_cfg_data[2:0];
                CFG_VOICE_REG: r_voice_reg <= i_cfg_data;
                CFG_FM_REG:    r_fm_reg    <= i_cfg_data;
                CFG_FM_EN:     r_fm_en     <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign vg = decode_gain(r_card_type, r_voice_reg, 1'b1);
    assign fg = decode_gain(r_card_type, r_fm_reg, 1'b0);

    always_comb begin
        st_en.s4 = !r_vo || !i_stall;
        st_en.s3 = !r_v3 || st_en.s4;
        st_en.s2 = !r_v2 || st_en.s3;
        st_en.s1 = !r_v1 || st_en.s2;
    end

    assign o_stall = !st_en.s1;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (st_en.s1) r_v1 <= i_valid;
            if (st_en.s2) r_v2 <= r_v1;
            if (st_en.s3) r_v3 <= r_v2;
            if (st_en.s4) r_vo <= r_v3;
        end
    end

    pfvm_lane u_left (
        .i_clk (i_clk),
        .i_en  (st_en),
        .i_dig (i_item.func),
        .i_fm  (r_fm_en),
        .i_pcm (i_item.pcm_left),
        .i_fmo (i_item.fm_left),
        .i_vg  (vg),
        .i_fg  (fg),
        .o_mix (o_item.mix_left)
    );

    pfvm_lane u_right (
        .i_clk (i_clk),
        .i_en  (st_en),
        .i_dig (i_item.func),
        .i_fm  (r_fm_en),
        .i_pcm (i_item.pcm_right),
        .i_fmo (i_item.fm_right),
        .i_vg  (vg),
        .i_fg  (fg),
        .o_mix (o_item.mix_right)
    );

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("accepted transaction missing from stage 1");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && r_v2 && r_v3 && r_vo && i_stall)
        else $error("input stalled with a free pipeline slot");

    a_s3_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !st_en.s4 |=> r_v3)
        else $error("stage 3 transaction lost while stalled");

    a_out_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && st_en.s4 |=> r_vo)
        else $error("stage 3 transaction did not reach output");

endmodule

[tb/testbench.sv]
// Self-checking testbench for pcm_fm_volume_mixer: a directed table, then random
// stereo frames under several register settings. Needs pfvm_pkg and the mixer RTL.
`timescale 1ns / 100ps

module testbench;
    import pfvm_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int LIMIT       = 100000;

    typedef struct {
        int card;
        int vreg;
        int freg;
        int fen;
        int func;
        int pl;
        int pr;
        int fl;
        int fr;
        int chk;
        int wl;
        int wr;
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    t_in_item              in_item    = '0;
    logic                  out_stall  = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_item;

    logic [2:0] cur_card = RST_CARD_TYPE;
    logic [7:0] cur_vreg = RST_VOICE_REG;
    logic [7:0] cur_freg = RST_FM_REG;
    logic       cur_fen  = RST_FM_EN;

    t_out_item pending_mix[$];
    int        err_count = 0;
    int        cycles    = 0;
    bit        burst     = 1'b0;
    bit        hold_req  = 1'b0;

    pcm_fm_volume_mixer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int gain_of(input logic [2:0] card, input logic [7:0] r,
                                   input bit voice);
        int k;
        int steps;
        if (card < CARD_PRO_FIRST) begin
            if (voice) begin
                k = int'(r[2:1]);
                steps = 3;
            end else begin
                k = int'(r[3:1]);
                steps = 7;
            end
        end else if (card == CARD_16BIT) begin
            k = int'(r[7:4]);
            steps = 15;
        end else begin
            k = int'(r[7:5]);
            steps = 7;
        end
        return (k * 256) / steps;
    endfunction

    function automatic logic [15:0] mix_lane(input bit dig, input bit fm,
                                             input logic signed [15:0] p,
                                             input logic signed [15:0] o,
                                             input int vg, input int fg);
        int     v;
        int     f;
        longint a;
        longint b;
        longint m;
        v = (int'(p) * vg) / 256;
        f = (int'(o) * fg) / 256;
        if (dig && fm) begin
            a = longint'(v) + 32768;
            b = longint'(f) + 32768;
            if (a < 32768 || b < 32768) begin
                m = (a * b) / 32768;
            end else begin
                m = 2 * (a + b) - (a * b) / 32768 - 65536;
            end
            if (m >= 65536) begin
                m = 65535;
            end
            return 16'(m - 32768);
        end else if (dig) begin
            return 16'(v);
        end else if (fm) begin
            return 16'(f);
        end
        return 16'd0;
    endfunction

    function automatic t_out_item mix_frame(input t_in_item it);
        t_out_item r;
        int        vg;
        int        fg;
        vg = gain_of(cur_card, cur_vreg, 1'b1);
        fg = gain_of(cur_card, cur_freg, 1'b0);
        r.mix_left  = mix_lane(it.func, cur_fen, it.pcm_left, it.fm_left, vg, fg);
        r.mix_right = mix_lane(it.func, cur_fen, it.pcm_right, it.fm_right, vg, fg);
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    // output monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_mix.size() == 0) begin
                report("unexpected transaction", out_item.mix_left, 0);
            end else begin
                want = pending_mix.pop_front();
                if (out_item.mix_left !== want.mix_left)
                    report("mix_left", out_item.mix_left, want.mix_left);
                if (out_item.mix_right !== want.mix_right)
                    report("mix_right", out_item.mix_right, want.mix_right);
            end
        end
    end

    // receiver: random stall per transaction, plus one long hold-off on request
    initial begin : receiver
        int w;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_stall <= 1'b1;
                end
            end
            w = burst ? 0 : $urandom_range(0, 4);
            repeat (w) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_frame(input t_in_item it, input int gap, input bit use_want,
                              input t_out_item want);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        pending_mix.push_back(use_want ? want : mix_frame(it));
    endtask

    task automatic drain_mix();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_CARD_TYPE: cur_card = data[2:0];
            CFG_VOICE_REG: cur_vreg = data;
            CFG_FM_REG:    cur_freg = data;
            CFG_FM_EN:     cur_fen  = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [2:0] card, input logic [7:0] vreg,
                             input logic [7:0] freg, input bit fen, input bit pad);
        logic [4:0] hi_card;
        logic [6:0] hi_en;
        hi_card = pad ? 5'($urandom) : 5'd0;
        hi_en   = pad ? 7'($urandom) : 7'd0;
        drain_mix();
        write_reg(CFG_CARD_TYPE, {hi_card, card});
        write_reg(CFG_VOICE_REG, vreg);
        write_reg(CFG_FM_REG, freg);
        write_reg(CFG_FM_EN, {hi_en, fen});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    t_row dir_rows[21];

    initial begin : stimulus
        t_in_item  it;
        t_out_item want;
        logic [2:0] c;
        logic [7:0] v;
        logic [7:0] f;
        bit         e;
        int         gap;

        dir_rows = '{
            // card vreg freg fen func  pl      pr      fl      fr     chk  wl      wr
            '{5, 255, 255, 1, 0,   1234,   -999,  32767, -32768, 1,  32767, -32768},
            '{5, 255, 255, 1, 1, -32768, -32768, -32768, -32768, 1, -32768, -32768},
            '{5, 255, 255, 1, 1,  32767,  32767,  32767,  32767, 1,  32767,  32767},
            '{5, 255, 255, 1, 1,      0,      0,      0,      0, 1,      0,      0},
            '{5, 255, 255, 1, 1, -32768,  32767,  32767, -32768, 1, -32768, -32768},
            '{5, 255, 255, 1, 1,     -1,    100,  20000,     -5, 0,      0,      0},
            '{5, 255, 255, 1, 1,  12345, -23456,   -111,  30000, 0,      0,      0},
            '{5, 255, 255, 0, 0,    500,    600,    700,    800, 1,      0,      0},
            '{5, 255, 255, 0, 1,  32767, -32768,      7,      7, 1,  32767, -32768},
            '{1,   6,  14, 1, 1, -32768,  32767, -32768,  32767, 1, -32768,  32767},
            '{1,   0,   0, 1, 1,  32767, -32768,  32767, -32768, 1,      0,      0},
            '{1,   0,   0, 1, 0,  32767, -32768,  32767, -32768, 1,      0,      0},
            '{0,   4,   9, 1, 1,  20000, -20000,  -9000,  31000, 0,      0,      0},
            '{0,   4,   9, 1, 0,   -333,    444,  -3001,  32767, 0,      0,      0},
            '{7, 160,  96, 1, 1, -12000,  32767,  15000, -32768, 0,      0,      0},
            '{7, 160,  96, 1, 0,      5,     -5,  -1000,   1000, 0,      0,      0},
            '{6, 240, 128, 1, 1,  32767,  -1234,  -4321,  32767, 0,      0,      0},
            '{6, 240, 128, 1, 0,    111,    222,  -7777,   7777, 0,      0,      0},
            '{6,  15, 255, 0, 1,  32767, -32768,   1234,  -1234, 1,      0,      0},
            '{4,  63, 224, 1, 1,     -7,    100, -32768,  32767, 0,      0,      0},
            '{4,  63, 224, 1, 1,   -100,  -3000,     -1,      1, 0,      0,      0}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (3'(dir_rows[i].card) != cur_card || 8'(dir_rows[i].vreg) != cur_vreg
                    || 8'(dir_rows[i].freg) != cur_freg || 1'(dir_rows[i].fen) != cur_fen) begin
                configure(3'(dir_rows[i].card), 8'(dir_rows[i].vreg),
                          8'(dir_rows[i].freg), 1'(dir_rows[i].fen), 1'b0);
            end
            it.func      = 1'(dir_rows[i].func);
            it.pcm_left  = 16'(dir_rows[i].pl);
            it.pcm_right = 16'(dir_rows[i].pr);
            it.fm_left   = 16'(dir_rows[i].fl);
            it.fm_right  = 16'(dir_rows[i].fr);
            want.mix_left  = 16'(dir_rows[i].wl);
            want.mix_right = 16'(dir_rows[i].wr);
            send_frame(it, $urandom_range(0, 4), 1'(dir_rows[i].chk), want);
        end

        want = '0;
        for (int ph = 0; ph < 12; ph++) begin
            c = 3'($urandom_range(0, 7));
            v = 8'($urandom);
            f = 8'($urandom);
            e = ($urandom_range(0, 3) != 0);
            case (ph)
                0: begin c = 3'd1; v = 8'd0;   f = 8'd0;   e = 1'b1; end
                1: begin c = 3'd6; v = 8'd255; f = 8'd255; e = 1'b1; end
                2: c = 3'd0;
                3: c = 3'd7;
                4: begin c = 3'd4; v = 8'd255; f = 8'd0;   e = 1'b0; end
                default: ;
            endcase
            configure(c, v, f, e, 1'b1);
            burst = (ph == 3);
            if (ph == 5)
                hold_req = 1'b1;
            for (int n = 0; n < 32; n++) begin
                it.func      = 1'($urandom);
                it.pcm_left  = rand_sample();
                it.pcm_right = rand_sample();
                it.fm_left   = rand_sample();
                it.fm_right  = rand_sample();
                gap = (burst || ph == 5) ? 0 : $urandom_range(0, 4);
                send_frame(it, gap, 1'b0, want);
            end
            burst = 1'b0;
        end

        drain_mix();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_mix.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
